@@ hw/rtl/tcc_pkg.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// tcc_pkg
// Shared types, level codes and helper functions for the toggle coverage
// counter.
// ---------------------------------------------------------------------------
package tcc_pkg;

  localparam int WATCHED_BITS = 64;
  localparam int IDX_W        = (WATCHED_BITS > 1) ? $clog2(WATCHED_BITS) : 1;
  localparam int CNT_W        = 31;
  localparam int CFG_AW       = 3;
  localparam int CFG_DW       = 32;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  localparam logic [3:0] LVL_U = 4'h0;
  localparam logic [3:0] LVL_X = 4'h1;
  localparam logic [3:0] LVL_0 = 4'h2;
  localparam logic [3:0] LVL_1 = 4'h3;
  localparam logic [3:0] LVL_Z = 4'h4;

  localparam logic REG_FROM_UNDEF = 1'b0;
  localparam logic REG_THROUGH_Z  = 1'b1;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_RISE = 2'd1,
    KIND_FALL = 2'd2
  } kind_t;

  typedef struct packed {
    logic from_undef;
    logic through_z;
  } cfg_t;

  typedef struct packed {
    logic [CNT_W-1:0] rise;
    logic [CNT_W-1:0] fall;
  } counts_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
  } store_rd_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    counts_t          data;
  } store_wr_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == CNT_MAX) ? v : v + CNT_W'(1);
  endfunction

  function automatic kind_t classify(input logic [3:0] old_lvl,
                                     input logic [3:0] new_lvl,
                                     input cfg_t       cfg);
    logic und;
    kind_t k;
    und = (old_lvl == LVL_U) || (old_lvl == LVL_X);
    k   = KIND_NONE;
    if (old_lvl == LVL_0 && new_lvl == LVL_1) begin
      k = KIND_RISE;
    end else if (old_lvl == LVL_1 && new_lvl == LVL_0) begin
      k = KIND_FALL;
    end else if (cfg.from_undef && und && new_lvl == LVL_1) begin
      k = KIND_RISE;
    end else if (cfg.from_undef && und && new_lvl == LVL_0) begin
      k = KIND_FALL;
    end else if (cfg.through_z && ((old_lvl == LVL_0 && new_lvl == LVL_Z) ||
                                   (old_lvl == LVL_Z && new_lvl == LVL_1))) begin
      k = KIND_RISE;
    end else if (cfg.through_z && ((old_lvl == LVL_1 && new_lvl == LVL_Z) ||
                                   (old_lvl == LVL_Z && new_lvl == LVL_0))) begin
      k = KIND_FALL;
    end
    return k;
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/tcc_if.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// tcc_if
// Valid/ready channels for bit-change words and counter result words.
// ---------------------------------------------------------------------------
interface tcc_in_if;
  logic       valid;
  logic       ready;
  logic [5:0] bit_index;
  logic [3:0] old_level;
  logic [3:0] new_level;

  modport source (output valid, output bit_index, output old_level, output new_level,
                  input ready);
  modport sink   (input valid, input bit_index, input old_level, input new_level,
                  output ready);
endinterface

interface tcc_out_if;
  logic        valid;
  logic        ready;
  logic [5:0]  bit_echo;
  logic [1:0]  transition_kind;
  logic [30:0] rise_total;
  logic [30:0] fall_total;

  modport source (output valid, output bit_echo, output transition_kind,
                  output rise_total, output fall_total, input ready);
  modport sink   (input valid, input bit_echo, input transition_kind,
                  input rise_total, input fall_total, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/toggle_coverage_counter.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// toggle_coverage_counter
// Toggle coverage monitor: per-bit saturating rise/fall counters.
// ---------------------------------------------------------------------------
// Takes one bit-change word per cycle unless the output is held, returning
// one result word per input word via the input stage with counter read,
// then the output register. The single read-modify-write of the counter
// memory sets throughput; a bypass keeps it at one word per cycle when not
// held, even for repeated hits on the same bit. Counters read as zero from
// reset via per-entry valid bits; no clearing pass. The user must write
// mode registers over APB only while the block is idle (not enforced).
// ---------------------------------------------------------------------------
module toggle_coverage_counter
  import tcc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  tcc_in_if.sink                 in_if,
  tcc_out_if.source              out_if,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [CFG_AW-1:0] paddr,
  input  wire logic [CFG_DW-1:0] pwdata,
  output      logic [CFG_DW-1:0] prdata,
  output      logic              pready
);

  cfg_t      cfg;
  store_rd_t st_rd;
  store_wr_t st_wr;
  counts_t   cur;

  logic       s1_vld_r;
  logic [5:0] s1_idx_r;
  logic [3:0] s1_old_r;
  logic [3:0] s1_new_r;

  logic        out_vld_r;
  logic [5:0]  out_idx_r;
  kind_t       out_kind_r;
  logic [30:0] out_rise_r;
  logic [30:0] out_fall_r;

  logic    in_acc;
  logic    s1_adv;
  logic    s1_rng;
  kind_t   s1_kind;
  counts_t s1_cnt;

  tcc_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  tcc_count_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd      (st_rd),
    .wr      (st_wr),
    .rd_data (cur)
  );

  assign s1_adv       = s1_vld_r && (!out_vld_r || out_if.ready);
  assign in_if.ready  = !s1_vld_r || s1_adv;
  assign in_acc       = in_if.valid && in_if.ready;

  assign st_rd.en   = in_acc;
  assign st_rd.addr = IDX_W'(in_if.bit_index);

  // classify and bump
  always_comb begin
    s1_rng  = 32'(s1_idx_r) < 32'(WATCHED_BITS);
    s1_kind = s1_rng ? classify(s1_old_r, s1_new_r, cfg) : KIND_NONE;
    s1_cnt  = cur;
    if (s1_kind == KIND_RISE) begin
      s1_cnt.rise = sat_inc(cur.rise);
    end else if (s1_kind == KIND_FALL) begin
      s1_cnt.fall = sat_inc(cur.fall);
    end
    if (!s1_rng) begin
      s1_cnt = '0;
    end
  end

  assign st_wr.en   = s1_adv && (s1_kind != KIND_NONE);
  assign st_wr.addr = IDX_W'(s1_idx_r);
  assign st_wr.data = s1_cnt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_vld_r <= 1'b1;
      end else if (s1_adv) begin
        s1_vld_r <= 1'b0;
      end
      if (s1_adv) begin
        out_vld_r <= 1'b1;
      end else if (out_if.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_idx_r <= in_if.bit_index;
      s1_old_r <= in_if.old_level;
      s1_new_r <= in_if.new_level;
    end
    if (s1_adv) begin
      out_idx_r  <= s1_idx_r;
      out_kind_r <= s1_kind;
      out_rise_r <= s1_cnt.rise;
      out_fall_r <= s1_cnt.fall;
    end
  end

  assign out_if.valid           = out_vld_r;
  assign out_if.bit_echo        = out_idx_r;
  assign out_if.transition_kind = out_kind_r;
  assign out_if.rise_total      = out_rise_r;
  assign out_if.fall_total      = out_fall_r;

  a_rise_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && (out_kind_r == KIND_RISE) |-> out_rise_r != '0)
    else $error("counted rise with zero rise total");

  a_fall_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && (out_kind_r == KIND_FALL) |-> out_fall_r != '0)
    else $error("counted fall with zero fall total");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_vld_r && !s1_vld_r)
    else $error("pipeline not empty after reset");

  a_write_adv: assert property (@(posedge clk) disable iff (!rst_n)
    st_wr.en |=> out_vld_r && (out_kind_r != KIND_NONE))
    else $error("counter write without counted result word");

endmodule
`default_nettype wire

@@ hw/rtl/tcc_cfg_regs.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// tcc_cfg_regs
// APB mode registers: count from undefined, count through Z.
// ---------------------------------------------------------------------------
module tcc_cfg_regs
  import tcc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [CFG_AW-1:0] paddr,
  input  wire logic [CFG_DW-1:0] pwdata,
  output      logic [CFG_DW-1:0] prdata,
  output      logic              pready,
  output      cfg_t              cfg
);

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        REG_FROM_UNDEF: cfg_r.from_undef <= pwdata[0];
        REG_THROUGH_Z:  cfg_r.through_z  <= pwdata[0];
        default:        cfg_r <= cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_FROM_UNDEF: prdata = {{(CFG_DW-1){1'b0}}, cfg_r.from_undef};
      REG_THROUGH_Z:  prdata = {{(CFG_DW-1){1'b0}}, cfg_r.through_z};
      default:        prdata = '0;
    endcase
  end

  assign pready = 1'b1;
  assign cfg    = cfg_r;

endmodule
`default_nettype wire

@@ hw/rtl/tcc_count_store.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// tcc_count_store
// Per-bit rise/fall counter memory: one read, one write a cycle, registered
// read data, per-entry valid bits for reset and write-to-read bypass.
// ---------------------------------------------------------------------------
module tcc_count_store
  import tcc_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire store_rd_t rd,
  input  wire store_wr_t wr,
  output      counts_t   rd_data
);

  counts_t                 mem [WATCHED_BITS];
  logic [WATCHED_BITS-1:0] vld_r;
  counts_t                 rd_mem_r;
  counts_t                 fwd_data_r;
  logic                    rd_vld_r;
  logic                    fwd_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd.en) begin
      rd_mem_r   <= mem[rd.addr];
      fwd_data_r <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
      fwd_r    <= 1'b0;
    end else begin
      if (wr.en) begin
        vld_r[wr.addr] <= 1'b1;
      end
      if (rd.en) begin
        rd_vld_r <= vld_r[rd.addr];
        fwd_r    <= wr.en && (wr.addr == rd.addr);
      end
    end
  end

  assign rd_data = fwd_r    ? fwd_data_r :
                   rd_vld_r ? rd_mem_r   : '0;

endmodule
`default_nettype wire
